[sv/rda_pkg.sv]
// Package for the rotary detent accumulator: field widths, reset values
// and the status struct shared by the sequencer and the divider.
// No dependencies.
package rda_pkg;

  localparam int COUNT_W      = 16;
  localparam int TIME_IN_W    = 48;
  localparam int THR_W        = 7;
  localparam int TIMEOUT_W    = 32;
  localparam int CLICK_W      = 16;
  localparam int PEND_W       = 17;
  localparam int CFG_DATA_W   = 32;
  localparam int TIME_WIDTH_DEF = 48;

  // divider: pending steps over threshold
  localparam int DIVIDEND_W = PEND_W;
  localparam int DIVISOR_W  = THR_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [THR_W-1:0]     THR_RESET     = 7'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd200000;

  // register indexes on the configuration port
  localparam logic CFG_DETENT_THR      = 1'b0;
  localparam logic CFG_ABANDON_TIMEOUT = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[sv/rda_divider.sv]
// Restoring divider, one quotient bit per cycle, separate subtract and compare.
// Depends on rda_pkg.
module rda_divider import rda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_status_t           status,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;

  logic [DIVISOR_W:0] rem_shift;
  logic [DIVISOR_W:0] rem_diff;
  logic               fits;

  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = (rem_shift >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;
  assign remainder   = rem;

endmodule

[sv/rotary_detent_accumulator_top.sv]
// Rotary detent accumulator: turns polled quadrature counter readings into
// detent clicks. Depends on rda_pkg and rda_divider.
//
// Input channel (in_valid/in_stall) carries one poll word: counter_value and
// time_us. Output channel (out_valid/out_stall) carries one result word per
// poll: click_count, click_direction, pending_dropped, pending_left.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 detent threshold, 1 abandon_timeout); write only while the block is idle.
//
// in_stall is low only while the sequencer is idle. A poll with no movement
// or too few steps for a click goes through the calculation and finish states
// to out_valid; one that fires clicks also waits in the division state on the
// bit-serial divider that splits the pending steps by the threshold. A new poll
// is accepted only once the previous one has left the finish state.
// The result sits in an output register, so the next poll is accepted while
// an earlier result is still stalled; the sequencer only waits when a new
// result is ready and the register is still held by out_stall.
// Reset (rst, synchronous) clears the counter history, pending steps and
// direction, empties the output register and restores the threshold to 2
// and the timeout to 200000 us.
module rotary_detent_accumulator_top import rda_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COUNT_W-1:0]   counter_value,
  input  logic [TIME_IN_W-1:0]        time_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CLICK_W-1:0]          click_count,
  output logic                        click_direction,
  output logic                        pending_dropped,
  output logic [PEND_W-1:0]           pending_left,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;

  logic [THR_W-1:0]     detent_thr;
  logic [TIMEOUT_W-1:0] abandon_timeout;

  logic [COUNT_W-1:0]    previous_count;
  logic [TIME_WIDTH-1:0] last_step_time;
  logic [PEND_W-1:0]     pending_count;
  logic                  pending_direction;

  logic [COUNT_W-1:0]    poll_count;
  logic [TIME_WIDTH-1:0] poll_time;

  logic [CLICK_W-1:0] res_clicks;
  logic               res_dir;
  logic               res_dropped;
  logic [PEND_W-1:0]  res_left;

  // time taken modulo 2^TIME_WIDTH
  logic [TIME_WIDTH+TIME_IN_W-1:0] time_ext;
  logic [TIME_WIDTH-1:0]           now;

  logic signed [COUNT_W:0] delta;
  logic                    move_dir;
  logic [COUNT_W-1:0]      move_mag;
  logic [PEND_W-1:0]       pend_sum;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic                    timed_out;
  logic [THR_W-1:0]        thr_eff;

  logic                  div_start;
  div_status_t           div_stat;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [DIVISOR_W-1:0]  div_rem;

  logic out_free;

  assign time_ext = {{TIME_WIDTH{1'b0}}, time_us};
  assign now      = time_ext[TIME_WIDTH-1:0];

  always_comb begin
    delta     = $signed({poll_count[COUNT_W-1], poll_count})
              - $signed({previous_count[COUNT_W-1], previous_count});
    move_dir  = !delta[COUNT_W];
    move_mag  = delta[COUNT_W] ? COUNT_W'(-delta) : delta[COUNT_W-1:0];
    elapsed   = poll_time - last_step_time;
    timed_out = (elapsed > TIME_WIDTH'(abandon_timeout));
    thr_eff   = (detent_thr == '0) ? THR_W'(1) : detent_thr;
    if (pending_count != '0 && move_dir == pending_direction) begin
      pend_sum = pending_count + PEND_W'(move_mag);
    end else begin
      pend_sum = PEND_W'(move_mag);
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_CALC) && (delta != '0)
                     && (pend_sum >= PEND_W'(thr_eff));

  rda_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (pend_sum),
    .divisor   (thr_eff),
    .status    (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_thr      <= THR_RESET;
      abandon_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DETENT_THR:      detent_thr      <= cfg_data[THR_W-1:0];
        CFG_ABANDON_TIMEOUT: abandon_timeout <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // poll capture and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      poll_count <= counter_value;
      poll_time  <= now;
    end
    if (state == S_FINISH && out_free) begin
      click_count     <= res_clicks;
      click_direction <= res_dir;
      pending_dropped <= res_dropped;
      pending_left    <= res_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      previous_count    <= '0;
      last_step_time    <= '0;
      pending_count     <= '0;
      pending_direction <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          res_clicks  <= '0;
          res_dir     <= 1'b0;
          if (delta == '0) begin
            if (pending_count != '0 && timed_out) begin
              pending_count <= '0;
              res_dropped   <= 1'b1;
              res_left      <= '0;
            end else begin
              res_dropped   <= 1'b0;
              res_left      <= pending_count;
            end
            state <= S_FINISH;
          end else begin
            res_dropped       <= 1'b0;
            previous_count    <= poll_count;
            last_step_time    <= poll_time;
            pending_count     <= pend_sum;
            res_left          <= pend_sum;
            if (!(pending_count != '0 && move_dir == pending_direction)) begin
              pending_direction <= move_dir;
            end
            state <= div_start ? S_DIV : S_FINISH;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_clicks    <= div_quo[CLICK_W-1:0];
            res_dir       <= pending_direction;
            pending_count <= PEND_W'(div_rem);
            res_left      <= PEND_W'(div_rem);
            state         <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider only finishes while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside division");

  // remainder left pending is below the threshold
  a_rem_below_thr: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_stat.done) |=> (pending_count < PEND_W'(thr_eff)))
    else $error("pending steps not reduced below threshold");

  // a new result only appears from the finishing step
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside finish");

  a_no_click_no_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && click_count == '0) |-> !click_direction)
    else $error("direction set without clicks");

  a_drop_no_clicks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pending_dropped) |-> (click_count == '0 && pending_left == '0))
    else $error("dropped poll carries clicks or pending steps");

endmodule

[sim/tb.sv]
// Self-checking bench for rotary_detent_accumulator_top: random and directed polls,
// a transaction-level predictor of the detent arithmetic, random input gaps and random output stalls.
// Depends on rda_pkg and the accumulator RTL.
module tb;
  import rda_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic [TIME_IN_W-1:0]      stamp;
  } poll_t;

  typedef struct packed {
    logic [CLICK_W-1:0] clicks;
    logic               dir;
    logic               dropped;
    logic [PEND_W-1:0]  left;
  } click_res_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COUNT_W-1:0] counter_value = '0;
  logic [TIME_IN_W-1:0]      time_us = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CLICK_W-1:0]        click_count;
  logic                      click_direction;
  logic                      pending_dropped;
  logic [PEND_W-1:0]         pending_left;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = CFG_DETENT_THR;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  rotary_detent_accumulator_top dut (.*);

  // tracked copy of the block's state and registers
  logic signed [COUNT_W-1:0] trk_prev = '0;
  logic [TIME_IN_W-1:0]      trk_last = '0;
  logic [PEND_W-1:0]         trk_pend = '0;
  logic                      trk_dir = 1'b0;
  logic [THR_W-1:0]          trk_thr = THR_RESET;
  logic [TIMEOUT_W-1:0]      trk_timeout = TIMEOUT_RESET;

  // stimulus generator's view of the poll history
  logic signed [COUNT_W-1:0] gen_prev = '0;
  logic [TIME_IN_W-1:0]      gen_last = '0;
  logic [TIME_IN_W-1:0]      gen_now = '0;
  int                        gen_sign = 1;

  poll_t      pending_polls[$];
  click_res_t exp_clicks[$];
  int         mismatches = 0;
  int         in_gap = 0, in_burst = 0;
  int         out_gap = 0, out_burst = 0;
  int         quiet = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic click_res_t detent_predict(poll_t p);
    int                   delta;
    int unsigned          mag, thr;
    logic [TIME_IN_W-1:0] elapsed;
    click_res_t           r;
    r = '0;
    delta = int'(p.count) - int'(trk_prev);
    if (delta == 0) begin
      if (trk_pend != 0) begin
        elapsed = p.stamp - trk_last;  // modulo 2**48
        if (elapsed > trk_timeout) begin
          trk_pend = '0;
          r.dropped = 1'b1;
        end
      end
    end else begin
      mag = (delta > 0) ? delta : -delta;
      thr = (trk_thr == 0) ? 1 : trk_thr;
      trk_prev = p.count;
      trk_last = p.stamp;
      if (trk_pend != 0 && (delta > 0) == trk_dir) begin
        trk_pend = PEND_W'(trk_pend + mag);
      end else begin
        trk_pend = PEND_W'(mag);
        trk_dir = (delta > 0);
      end
      if (trk_pend >= thr) begin
        r.clicks = CLICK_W'(trk_pend / thr);
        trk_pend = PEND_W'(trk_pend % thr);
        r.dir = trk_dir;
      end
    end
    r.left = trk_pend;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : drive_polls
    poll_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        exp_clicks.push_back(detent_predict(poll_t'{counter_value, time_us}));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_polls.size() > 0) begin
          nxt = pending_polls.pop_front();
          in_valid <= 1'b1;
          counter_value <= nxt.count;
          time_us <= nxt.stamp;
          in_gap <= pick_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_clicks
    click_res_t e;
    int g;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_clicks.size() == 0) begin
          flag_error("result word with no poll outstanding");
        end else begin
          e = exp_clicks.pop_front();
          if (click_count !== e.clicks)
            flag_error($sformatf("click_count %0d, want %0d", click_count, e.clicks));
          if (click_direction !== e.dir)
            flag_error($sformatf("click_direction %0b, want %0b", click_direction, e.dir));
          if (pending_dropped !== e.dropped)
            flag_error($sformatf("pending_dropped %0b, want %0b", pending_dropped, e.dropped));
          if (pending_left !== e.left)
            flag_error($sformatf("pending_left %0d, want %0d", pending_left, e.left));
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? pick_gap(out_burst) : 0;
        out_stall <= (g > 0);
        out_gap <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_poll(logic signed [COUNT_W-1:0] c, logic [TIME_IN_W-1:0] t);
    pending_polls.push_back(poll_t'{c, t});
    if (c != gen_prev) gen_last = t;
    gen_prev = c;
    gen_now = t;
  endtask

  task automatic cfg_write(logic idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_DETENT_THR) trk_thr = data[THR_W-1:0];
    else trk_timeout = data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sampled on the falling edge so queue and valid updates have settled
  task automatic drain();
    @(negedge clk);
    while (pending_polls.size() != 0 || in_valid || exp_clicks.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic edge_polls();
    int unsigned thr;
    thr = (trk_thr == 0) ? 1 : trk_thr;
    queue_poll(COUNT_W'(gen_prev + thr), gen_now + 7);       // a move of exactly one threshold
    queue_poll(COUNT_W'(gen_prev + thr - 1), gen_now + 7);   // one step short when same way
    queue_poll(gen_prev, gen_last + trk_timeout);  // still for exactly the timeout
    queue_poll(gen_prev, gen_last + trk_timeout + 1);
    queue_poll(COUNT_W'(gen_prev - 1), gen_now + 3);         // reversal
  endtask

  task automatic random_poll();
    int                        r, d;
    int unsigned               thr;
    logic signed [COUNT_W-1:0] c;
    logic [TIME_IN_W-1:0]      t;
    thr = (trk_thr == 0) ? 1 : trk_thr;
    r = $urandom_range(0, 99);
    c = gen_prev;
    t = gen_now + $urandom_range(1, 5000);
    if (r < 55) begin
      d = $urandom_range(1, thr + 2);
      if ($urandom_range(0, 6) == 0) gen_sign = -gen_sign;
      c = COUNT_W'(gen_prev + gen_sign * d);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: t = gen_last + trk_timeout - 1;
        1: t = gen_last + trk_timeout;
        2: t = gen_last + trk_timeout + 1;
        default: t = gen_now + $urandom_range(0, 100000);
      endcase
    end else if (r < 90) begin
      c = COUNT_W'($urandom);
      t = gen_now + $urandom_range(0, 300000);
    end else begin
      if ($urandom_range(0, 1) == 0) t = TIME_IN_W'({$urandom, $urandom});
      else t = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 2000);
      c = COUNT_W'(gen_prev + gen_sign * int'($urandom_range(0, 3)));
    end
    queue_poll(c, t);
  endtask

  initial begin : stimulus
    logic [THR_W-1:0]      thr;
    logic [TIMEOUT_W-1:0]  tmo;
    logic [CFG_DATA_W-1:0] thr_word;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold 2, timeout 200000
    queue_poll(0, 0);
    queue_poll(1, 10);
    queue_poll(2, 20);
    queue_poll(3, 30);
    queue_poll(3, 30 + 200000);           // equal to timeout: kept
    queue_poll(3, 30 + 200001);           // one past: dropped
    queue_poll(2, 200100);
    queue_poll(0, 200200);
    queue_poll(16'sh7FFF, 200300);
    queue_poll(-32768, 200400);           // largest negative change
    queue_poll(16'sh7FFF, 200500);        // largest positive change
    queue_poll(32766, 48'hFFFF_FFFF_FFF0);
    queue_poll(32766, 48'h10);            // timer wrapped, short elapsed
    queue_poll(32766, 48'h10 + 200000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin thr = 0;   tmo = 0;             end
        1: begin thr = 1;   tmo = 1000;          end
        2: begin thr = 127; tmo = 32'hFFFF_FFFF; end
        3: begin thr = 64;  tmo = 50;            end
        4: begin thr = 3;   tmo = 200000;        end
        5: begin thr = 65;  tmo = 0;             end
        default: begin
          thr = THR_W'($urandom_range(0, 127));
          tmo = $urandom_range(0, 100000);
        end
      endcase
      // upper data bits of the threshold word are don't-care
      thr_word = {(($urandom_range(0, 1) == 0) ? 25'd0 : 25'($urandom)), thr};
      if (ph % 2 == 0) begin
        cfg_write(CFG_DETENT_THR, thr_word);
        cfg_write(CFG_ABANDON_TIMEOUT, tmo);
      end else begin
        cfg_write(CFG_ABANDON_TIMEOUT, tmo);
        cfg_write(CFG_DETENT_THR, thr_word);
      end
      edge_polls();
      repeat (180) random_poll();
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
